// File: rtl/fbca_pkg.sv
package fbca_pkg;

    localparam int BLOCKS           = 2048;
    localparam int FIRST_DATA_BLOCK = 9;

    localparam int IDX_W  = 11;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;
    localparam int STEP_W = $clog2(BLOCKS + 1);

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD    = 2'd2;

    // opcodes; the last two are spare
    typedef enum logic [OP_W-1:0] {
        OP_FORMAT    = 3'd0,
        OP_ALLOC     = 3'd1,
        OP_APPEND    = 3'd2,
        OP_FIND_LAST = 3'd3,
        OP_NEXT      = 3'd4,
        OP_FREE      = 3'd5,
        OP_SPARE6    = 3'd6,
        OP_SPARE7    = 3'd7
    } op_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_block;
        logic [ST_W-1:0]  status;
    } res_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

// File: rtl/fbca_ram.sv
module fbca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fbca_ctrl.sv
module fbca_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [fbca_pkg::OP_W-1:0]   in_opcode,
    input  logic [fbca_pkg::IDX_W-1:0]  in_block,
    output logic                        res_valid,
    output fbca_pkg::res_t              res,
    input  logic                        res_ready,
    output fbca_pkg::ram_req_t          ram_req,
    input  logic [fbca_pkg::IDX_W-1:0]  ram_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_POP    = 3'd2;
    localparam logic [2:0] S_APPWR  = 3'd3;
    localparam logic [2:0] S_NEXT   = 3'd4;
    localparam logic [2:0] S_WALK   = 3'd5;
    localparam logic [2:0] S_FMT    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [fbca_pkg::IDX_W-1:0] IDX_ZERO  = '0;
    localparam logic [fbca_pkg::IDX_W-1:0] IDX_FIRST =
        fbca_pkg::IDX_W'(fbca_pkg::FIRST_DATA_BLOCK);
    localparam logic [fbca_pkg::IDX_W-1:0] IDX_LAST  =
        fbca_pkg::IDX_W'(fbca_pkg::BLOCKS - 1);
    localparam logic [fbca_pkg::STEP_W-1:0] STEP_MAX =
        fbca_pkg::STEP_W'(fbca_pkg::BLOCKS);

    function automatic logic is_data(input logic [fbca_pkg::IDX_W-1:0] b);
        return ({1'b0, b} >= {1'b0, IDX_FIRST}) &&
               ({1'b0, b} < (fbca_pkg::IDX_W + 1)'(fbca_pkg::BLOCKS));
    endfunction

    logic [2:0]                     state_reg, state_next;
    logic [fbca_pkg::OP_W-1:0]      op_reg, op_next;
    logic [fbca_pkg::IDX_W-1:0]     blk_reg, blk_next;
    logic [fbca_pkg::IDX_W-1:0]     cur_reg, cur_next;
    logic [fbca_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [fbca_pkg::IDX_W-1:0]     free_head_reg, free_head_next;
    fbca_pkg::res_t                 hold_reg, hold_next;

    logic                           fin;
    fbca_pkg::res_t                 fin_res;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        blk_next       = blk_reg;
        cur_next       = cur_reg;
        step_next      = step_reg;
        free_head_next = free_head_reg;
        hold_next      = hold_reg;
        fin            = 1'b0;
        fin_res        = '{result_block: IDX_ZERO, status: fbca_pkg::ST_OK};
        ram_req.we     = 1'b0;
        ram_req.waddr  = cur_reg;
        ram_req.wdata  = IDX_ZERO;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next    = in_opcode;
                    blk_next   = in_block;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (op_reg) inside
                    fbca_pkg::OP_FORMAT: begin
                        cur_next   = IDX_FIRST;
                        state_next = S_FMT;
                    end
                    fbca_pkg::OP_ALLOC, fbca_pkg::OP_APPEND: begin
                        if (op_reg == fbca_pkg::OP_APPEND && !is_data(blk_reg)) begin
                            fin            = 1'b1;
                            fin_res.status = fbca_pkg::ST_BAD;
                        end else if (!is_data(free_head_reg)) begin
                            fin            = 1'b1;
                            fin_res.status = fbca_pkg::ST_NOFREE;
                        end else begin
                            cur_next   = free_head_reg;
                            state_next = S_POP;
                        end
                    end
                    fbca_pkg::OP_FIND_LAST, fbca_pkg::OP_NEXT: begin
                        if (!is_data(blk_reg)) begin
                            fin            = 1'b1;
                            fin_res.status = fbca_pkg::ST_BAD;
                        end else begin
                            cur_next   = blk_reg;
                            step_next  = fbca_pkg::STEP_W'(1);
                            state_next = (op_reg == fbca_pkg::OP_FIND_LAST) ? S_WALK : S_NEXT;
                        end
                    end
                    fbca_pkg::OP_FREE: begin
                        if (!is_data(blk_reg)) begin
                            fin            = 1'b1;
                            fin_res.status = fbca_pkg::ST_BAD;
                        end else if (!is_data(free_head_reg)) begin
                            // empty free list: chain becomes the list
                            free_head_next = blk_reg;
                            fin            = 1'b1;
                        end else begin
                            cur_next   = free_head_reg;
                            step_next  = fbca_pkg::STEP_W'(1);
                            state_next = S_WALK;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_POP: begin
                // rdata = link of the old free head
                free_head_next = ram_rdata;
                ram_req.we     = 1'b1;
                ram_req.waddr  = cur_reg;
                ram_req.wdata  = IDX_ZERO;
                if (op_reg == fbca_pkg::OP_APPEND) begin
                    state_next = S_APPWR;
                end else begin
                    fin                  = 1'b1;
                    fin_res.result_block = cur_reg;
                end
            end
            S_APPWR: begin
                ram_req.we           = 1'b1;
                ram_req.waddr        = blk_reg;
                ram_req.wdata        = cur_reg;
                fin                  = 1'b1;
                fin_res.result_block = cur_reg;
            end
            S_NEXT: begin
                fin                  = 1'b1;
                fin_res.result_block = ram_rdata;
            end
            S_WALK: begin
                if (ram_rdata == IDX_ZERO) begin
                    fin = 1'b1;
                    if (op_reg == fbca_pkg::OP_FIND_LAST) begin
                        fin_res.result_block = cur_reg;
                    end else begin
                        // splice freed chain after the free-list tail
                        ram_req.we    = 1'b1;
                        ram_req.waddr = cur_reg;
                        ram_req.wdata = blk_reg;
                    end
                end else if (!is_data(ram_rdata) || step_reg == STEP_MAX) begin
                    fin            = 1'b1;
                    fin_res.status = fbca_pkg::ST_BAD;
                end else begin
                    cur_next  = ram_rdata;
                    step_next = step_reg + fbca_pkg::STEP_W'(1);
                end
            end
            S_FMT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cur_reg;
                if (cur_reg == IDX_LAST) begin
                    ram_req.wdata  = IDX_ZERO;
                    free_head_next = IDX_FIRST;
                    fin            = 1'b1;
                end else begin
                    ram_req.wdata = cur_reg + fbca_pkg::IDX_W'(1);
                    cur_next      = cur_reg + fbca_pkg::IDX_W'(1);
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin) begin
            hold_next  = fin_res;
            state_next = res_ready ? S_IDLE : S_DONE;
        end

        // read the entry the next cycle will look at
        ram_req.raddr = cur_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = fin || (state_reg == S_DONE);
    assign res       = fin ? fin_res : hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
        end
        op_reg   <= op_next;
        blk_reg  <= blk_next;
        cur_reg  <= cur_next;
        step_reg <= step_next;
        hold_reg <= hold_next;
    end

endmodule

// File: rtl/fat_block_chain_allocator_top.sv
// Block-chain allocator over a file-allocation link table held in one
// 2048 x 11 synchronous RAM, plus a free-list head register. One transaction
// is processed at a time; the input is ready again as soon as the result is
// handed to the output register, even while that result waits on m_ready.
// Work per operation, up to the result entering the output register: next,
// find-last or free on a reserved index, unused opcodes and the empty-list
// cases finish in decode; allocate and next read one link; append also writes
// the tail's link; find-last walks from its block and free from the free-list
// head, one RAM read per cycle, the start's own link included (at most 2048
// reads before the walk limit); format sweeps one RAM write per data block.
// Before the first format the link table holds garbage; no operation other
// than format should touch it until then.
module fat_block_chain_allocator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fbca_pkg::OP_W-1:0]         s_opcode,
    input  logic [fbca_pkg::IDX_W-1:0]        s_block,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fbca_pkg::IDX_W-1:0]        m_result_block,
    output logic [fbca_pkg::ST_W-1:0]         m_status
);

    fbca_pkg::res_t                  res;
    fbca_pkg::ram_req_t              ram_req;
    logic                            res_valid;
    logic                            res_ready;
    logic [fbca_pkg::IDX_W-1:0]      ram_rdata;

    logic                            m_valid_reg;
    logic [fbca_pkg::IDX_W-1:0]      m_result_block_reg;
    logic [fbca_pkg::ST_W-1:0]       m_status_reg;

    // Sequencer: decode, pop, walk and format sweep.
    fbca_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_opcode (s_opcode),
        .in_block  (s_block),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Link table: one write, one read per cycle, read data registered.
    fbca_ram #(
        .WIDTH (fbca_pkg::IDX_W),
        .DEPTH (fbca_pkg::BLOCKS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Output register: takes a new result when empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_result_block_reg <= res.result_block;
            m_status_reg       <= res.status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_block = m_result_block_reg;
    assign m_status       = m_status_reg;

endmodule

// File: dv/tb_fat_block_chain_allocator_top.sv
module tb_fat_block_chain_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Quiet-cycle limit. The slowest single operation is a walk of the whole
    // table or a format sweep, plus a receiver stall; STALL_LIMIT is a multiple
    // of BLOCKS.
    localparam int STALL_LIMIT = 5 * fbca_pkg::BLOCKS;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_CHAINS  = 12;
    localparam int PAUSE_EVERY = 150;

    // Link table shadow, free-list head and the queue of expected results.
    class chain_scoreboard;
        logic [fbca_pkg::IDX_W-1:0] link_mem [fbca_pkg::BLOCKS];
        logic [fbca_pkg::IDX_W-1:0] free_head;
        fbca_pkg::res_t             expected_q[$];
        int unsigned                errors;

        function new();
            foreach (link_mem[i]) link_mem[i] = '0;
            free_head = '0;
            errors    = 0;
        endfunction

        function bit is_data(input logic [fbca_pkg::IDX_W-1:0] b);
            return int'(b) >= fbca_pkg::FIRST_DATA_BLOCK && int'(b) < fbca_pkg::BLOCKS;
        endfunction

        // Follow links to the block whose link is zero.
        function logic [fbca_pkg::ST_W-1:0] walk_end(
                input logic [fbca_pkg::IDX_W-1:0] start,
                output logic [fbca_pkg::IDX_W-1:0] last);
            logic [fbca_pkg::IDX_W-1:0] cur;
            logic [fbca_pkg::IDX_W-1:0] nxt;
            cur  = start;
            last = '0;
            for (int n = 0; n < fbca_pkg::BLOCKS; n++) begin
                nxt = link_mem[cur];
                if (nxt == '0) begin
                    last = cur;
                    return fbca_pkg::ST_OK;
                end
                if (!is_data(nxt)) return fbca_pkg::ST_BAD;
                cur = nxt;
            end
            return fbca_pkg::ST_BAD;
        endfunction

        function logic [fbca_pkg::IDX_W-1:0] pop_free();
            logic [fbca_pkg::IDX_W-1:0] h;
            h = free_head;
            if (!is_data(h)) return '0;
            free_head   = link_mem[h];
            link_mem[h] = '0;
            return h;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Applies one accepted input transaction and queues its result.
        function fbca_pkg::res_t note_input(input fbca_pkg::op_t op,
                                            input logic [fbca_pkg::IDX_W-1:0] blk);
            fbca_pkg::res_t             r;
            logic [fbca_pkg::IDX_W-1:0] h;
            logic [fbca_pkg::IDX_W-1:0] last;
            r.result_block = '0;
            r.status       = fbca_pkg::ST_OK;
            case (op)
                fbca_pkg::OP_FORMAT: begin
                    for (int i = fbca_pkg::FIRST_DATA_BLOCK; i < fbca_pkg::BLOCKS - 1; i++)
                        link_mem[i] = fbca_pkg::IDX_W'(i + 1);
                    link_mem[fbca_pkg::BLOCKS-1] = '0;
                    free_head = fbca_pkg::IDX_W'(fbca_pkg::FIRST_DATA_BLOCK);
                end
                fbca_pkg::OP_ALLOC: begin
                    h = pop_free();
                    if (h == '0) r.status = fbca_pkg::ST_NOFREE;
                    else r.result_block = h;
                end
                fbca_pkg::OP_APPEND: begin
                    if (!is_data(blk)) begin
                        r.status = fbca_pkg::ST_BAD;
                    end else begin
                        h = pop_free();
                        if (h == '0) begin
                            r.status = fbca_pkg::ST_NOFREE;
                        end else begin
                            link_mem[blk]  = h;
                            r.result_block = h;
                        end
                    end
                end
                fbca_pkg::OP_FIND_LAST: begin
                    if (!is_data(blk)) begin
                        r.status = fbca_pkg::ST_BAD;
                    end else begin
                        r.status = walk_end(blk, last);
                        if (r.status == fbca_pkg::ST_OK) r.result_block = last;
                    end
                end
                fbca_pkg::OP_NEXT: begin
                    if (!is_data(blk)) r.status = fbca_pkg::ST_BAD;
                    else r.result_block = link_mem[blk];
                end
                fbca_pkg::OP_FREE: begin
                    if (!is_data(blk)) begin
                        r.status = fbca_pkg::ST_BAD;
                    end else if (!is_data(free_head)) begin
                        free_head = blk;
                    end else begin
                        r.status = walk_end(free_head, last);
                        if (r.status == fbca_pkg::ST_OK) link_mem[last] = blk;
                    end
                end
                default: begin
                end
            endcase
            expected_q.push_back(r);
            return r;
        endfunction

        function void check_result(input logic [fbca_pkg::IDX_W-1:0] rb,
                                   input logic [fbca_pkg::ST_W-1:0] st);
            fbca_pkg::res_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction: result_block=%0d status=%0d", rb, st);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (rb !== e.result_block) begin
                $error("result_block: expected %0d, actual %0d", e.result_block, rb);
                errors++;
            end
            if (st !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn        = 1'b0;
    logic                             s_valid        = 1'b0;
    logic                             s_ready;
    logic [fbca_pkg::OP_W-1:0]        s_opcode       = '0;
    logic [fbca_pkg::IDX_W-1:0]       s_block        = '0;
    logic                             m_valid;
    logic                             m_ready        = 1'b0;
    logic [fbca_pkg::IDX_W-1:0]       m_result_block;
    logic [fbca_pkg::ST_W-1:0]        m_status;

    chain_scoreboard                  sb = new();

    // Chain starts handed out by allocate; the well-formed stimulus works on these.
    logic [fbca_pkg::IDX_W-1:0]       chain_starts[$];

    // Idle odds in percent per cycle, changed between phases.
    int unsigned                      src_idle_pct = 7;
    int unsigned                      dst_idle_pct = 48;
    int unsigned                      quiet_cycles = 0;

    fat_block_chain_allocator_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_block        (s_block),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_block (m_result_block),
        .m_status       (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: sample at the edge (pre-update values), check an accepted
    // transaction, then pick ready for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_result_block, m_status);
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Watchdog: cycles in which neither channel completes a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Tail of a chain by the shadow table; a broken chain falls back to its start.
    function automatic logic [fbca_pkg::IDX_W-1:0] chain_tail(
            input logic [fbca_pkg::IDX_W-1:0] start);
        logic [fbca_pkg::IDX_W-1:0] last;
        if (sb.walk_end(start, last) == fbca_pkg::ST_OK) return last;
        return start;
    endfunction

    // Present one input transaction and hold it until accepted. Valid is only
    // lowered during a sender gap, so back-to-back items keep it high.
    task automatic send_item(input fbca_pkg::op_t op,
                             input logic [fbca_pkg::IDX_W-1:0] blk,
                             output fbca_pkg::res_t exp_r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_block  <= blk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp_r = sb.note_input(op, blk);
        if (op == fbca_pkg::OP_FORMAT)
            chain_starts.delete();
        else if (op == fbca_pkg::OP_ALLOC && exp_r.status == fbca_pkg::ST_OK)
            chain_starts.push_back(exp_r.result_block);
    endtask

    task automatic run_directed();
        fbca_pkg::res_t r;
        // Before the first format nothing may read the link table, so only
        // reserved operands, empty-list cases and spare opcodes go in here.
        send_item(fbca_pkg::OP_ALLOC,     11'd0,    r);   // empty list right after reset
        send_item(fbca_pkg::OP_APPEND,    11'd2047, r);   // empty list, legal tail
        send_item(fbca_pkg::OP_APPEND,    11'd3,    r);   // reserved tail
        send_item(fbca_pkg::OP_NEXT,      11'd0,    r);   // reserved query
        send_item(fbca_pkg::OP_FIND_LAST, 11'd8,    r);   // last reserved index
        send_item(fbca_pkg::OP_FREE,      11'd5,    r);   // reserved start
        send_item(fbca_pkg::OP_SPARE6,    11'd2047, r);
        send_item(fbca_pkg::OP_SPARE7,    11'd1024, r);
        send_item(fbca_pkg::OP_FREE,      11'd2047, r);   // onto empty list: becomes head
        send_item(fbca_pkg::OP_FORMAT,    11'd1365, r);
        send_item(fbca_pkg::OP_ALLOC,     11'd2047, r);   // first data block
        send_item(fbca_pkg::OP_APPEND,    11'd9,    r);
        send_item(fbca_pkg::OP_APPEND,    11'd10,   r);
        send_item(fbca_pkg::OP_NEXT,      11'd9,    r);
        send_item(fbca_pkg::OP_NEXT,      11'd11,   r);   // end of chain
        send_item(fbca_pkg::OP_NEXT,      11'd2047, r);   // end of free list
        send_item(fbca_pkg::OP_FIND_LAST, 11'd9,    r);
        send_item(fbca_pkg::OP_FIND_LAST, 11'd2047, r);
        send_item(fbca_pkg::OP_FREE,      11'd9,    r);   // spliced after the free tail
        send_item(fbca_pkg::OP_NEXT,      11'd2047, r);
        send_item(fbca_pkg::OP_FREE,      11'd100,  r);   // already free: free list loops
        send_item(fbca_pkg::OP_FIND_LAST, 11'd12,   r);   // walk limit
        send_item(fbca_pkg::OP_FREE,      11'd50,   r);   // walk limit, no change
        send_item(fbca_pkg::OP_FORMAT,    11'd0,    r);
    endtask

    // Mostly well-formed file activity on live chains, some raw noise.
    // Every PAUSE_EVERY items the sender holds off until the result queue drains.
    task automatic run_random(input int unsigned n_items);
        fbca_pkg::op_t              op;
        logic [fbca_pkg::IDX_W-1:0] blk;
        fbca_pkg::res_t             r;
        int unsigned                pick;
        int unsigned                k;
        for (int unsigned n = 0; n < n_items; n++) begin
            if (n % PAUSE_EVERY == PAUSE_EVERY - 1) begin
                s_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
            end
            pick = $urandom_range(99);
            if ($urandom_range(99) < 10) begin
                op  = fbca_pkg::op_t'($urandom_range(7));
                blk = fbca_pkg::IDX_W'($urandom_range(fbca_pkg::BLOCKS - 1));
            end else if (chain_starts.size() == 0 ||
                         (pick < 20 && chain_starts.size() < MAX_CHAINS)) begin
                op  = fbca_pkg::OP_ALLOC;
                blk = fbca_pkg::IDX_W'($urandom_range(fbca_pkg::BLOCKS - 1));
            end else begin
                k = $urandom_range(chain_starts.size() - 1);
                if (pick < 50) begin
                    op  = fbca_pkg::OP_APPEND;
                    blk = chain_tail(chain_starts[k]);
                end else if (pick < 65) begin
                    op  = fbca_pkg::OP_FIND_LAST;
                    blk = chain_starts[k];
                end else if (pick < 80) begin
                    op  = fbca_pkg::OP_NEXT;
                    blk = $urandom_range(1) ? chain_starts[k]
                        : fbca_pkg::IDX_W'($urandom_range(fbca_pkg::BLOCKS - 1,
                                                          fbca_pkg::FIRST_DATA_BLOCK));
                end else if (pick < 99) begin
                    op  = fbca_pkg::OP_FREE;
                    blk = chain_starts[k];
                    chain_starts.delete(k);
                end else begin
                    op  = fbca_pkg::OP_FORMAT;
                    blk = fbca_pkg::IDX_W'($urandom_range(fbca_pkg::BLOCKS - 1));
                end
            end
            send_item(op, blk, r);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase 1: sender rarely idles, receiver stalls often.
        run_directed();
        run_random(600);

        // Phase 2: roles swapped.
        src_idle_pct = 48;
        dst_idle_pct = 7;
        run_random(550);

        // Phase 3: no idling.
        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_random(550);

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        // Let any stray result transaction show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
